// File: rtl/core/arpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsd_pkg: shared types for the ARP binding spoof detector
// Word formats on both sides of the block, the command word that travels from
// the front end to the back end, the table entry format and the FSM states.
// ----------------------------------------------------------------------------
package arpsd_pkg;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [7:0]  DEAUTH_FC     = 8'hC0;
    localparam int          QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_LEARNED = 2'd1,
        EV_SPOOF   = 2'd2,
        EV_FULL    = 2'd3
    } event_t;

    typedef enum logic {
        MODE_FRAME = 1'b0,
        MODE_HOP   = 1'b1
    } mode_t;

    typedef struct packed {
        logic        mode;
        logic        frame_is_mgmt;
        logic [7:0]  first_byte;
        logic [15:0] ether_type;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
    } in_word_t;

    typedef struct packed {
        event_t      arp_event;
        logic        deauth_seen;
        logic [47:0] bound_mac;
        logic [3:0]  channel;
    } out_word_t;

    // Classified work for the back end.
    typedef struct packed {
        logic        lookup;
        logic        deauth;
        logic [3:0]  channel;
        logic [47:0] mac;
        logic [31:0] ip;
    } cmd_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

    // Handshake between the command queue and its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

endpackage

// File: rtl/core/arpsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsd_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arpsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/arpsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsd_front: input acceptance and classification
// Accepts words, tracks the radio channel and turns each word into a command.
// ----------------------------------------------------------------------------
module arpsd_front
    import arpsd_pkg::*;
#(
    parameter int CHANNEL_COUNT = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  in_word_t      frame_word,
    input  queue_status_t q_status,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic [3:0] channel_reg;
    logic [3:0] channel_next;
    logic       accept;
    logic       is_hop;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;
    assign is_hop = (frame_word.mode == MODE_HOP);
    assign q_push = accept;

    always_comb
    begin
        channel_next = channel_reg;
        if (accept && is_hop)
        begin
            if (channel_reg >= 4'(CHANNEL_COUNT))
            begin
                channel_next = 4'd1;
            end
            else
            begin
                channel_next = channel_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= 4'd1;
        end
        else
        begin
            channel_reg <= channel_next;
        end
    end

    always_comb
    begin
        q_cmd.lookup  = !is_hop && (frame_word.ether_type == ETHERTYPE_ARP);
        q_cmd.deauth  = !is_hop && frame_word.frame_is_mgmt
                        && (frame_word.first_byte == DEAUTH_FC);
        q_cmd.channel = channel_next;
        q_cmd.mac     = frame_word.sender_mac;
        q_cmd.ip      = frame_word.sender_ip;
    end

endmodule

// File: rtl/core/arpsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsd_queue: command queue between front end and back end
// A small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module arpsd_queue
    import arpsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_push,
    input  cmd_t          q_cmd,
    input  logic          q_pop,
    output cmd_t          q_head,
    output queue_status_t q_status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign q_status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = q_push && !q_status.full;
    assign do_pop         = q_pop && !q_status.empty;
    assign q_head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_cmd;
        end
    end

endmodule

// File: rtl/core/arpsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpsd_back: binding table engine and result register
// Scans the learned entries one per cycle, learns or flags, and holds the
// result word until it is popped.
// ----------------------------------------------------------------------------
module arpsd_back
    import arpsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          q_head,
    input  queue_status_t q_status,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output out_word_t     result_word
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [UW-1:0] used_reg;
    logic [UW-1:0] used_next;
    logic [UW-1:0] idx_inc;
    cmd_t          cmd_reg;
    cmd_t          cmd_next;
    event_t        ev_reg;
    event_t        ev_next;
    logic [47:0]   stored_reg;
    logic [47:0]   stored_next;
    out_word_t     out_reg;
    out_word_t     out_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_rdata;

    arpsd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_inc     = UW'(idx_reg) + UW'(1);
    assign empty       = !out_valid_reg;
    assign result_word = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        cmd_next       = cmd_reg;
        ev_next        = ev_reg;
        stored_next    = stored_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = used_reg[IW-1:0];
        ram_wdata      = '{ip: cmd_reg.ip, mac: cmd_reg.mac};
        ram_raddr      = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_head;
                    ev_next     = EV_NONE;
                    stored_next = '0;
                    idx_next    = '0;
                    if (!q_head.lookup)
                    begin
                        state_next = BK_FINISH;
                    end
                    else if (used_reg == '0)
                    begin
                        // Empty table: learn straight into entry zero.
                        ram_we     = 1'b1;
                        ram_wdata  = '{ip: q_head.ip, mac: q_head.mac};
                        used_next  = UW'(1);
                        ev_next    = EV_LEARNED;
                        state_next = BK_FINISH;
                    end
                    else
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end

            BK_SCAN:
            begin
                ram_raddr = idx_inc[IW-1:0];
                if (ram_rdata.ip == cmd_reg.ip)
                begin
                    if (ram_rdata.mac != cmd_reg.mac)
                    begin
                        ev_next     = EV_SPOOF;
                        stored_next = ram_rdata.mac;
                    end
                    state_next = BK_FINISH;
                end
                else if (idx_inc < used_reg)
                begin
                    idx_next = idx_reg + IW'(1);
                end
                else if (used_reg < UW'(TABLE_ENTRIES))
                begin
                    ram_we     = 1'b1;
                    used_next  = used_reg + UW'(1);
                    ev_next    = EV_LEARNED;
                    state_next = BK_FINISH;
                end
                else
                begin
                    ev_next    = EV_FULL;
                    state_next = BK_FINISH;
                end
            end

            BK_FINISH:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.arp_event   = ev_reg;
                    out_next.deauth_seen = cmd_reg.deauth;
                    out_next.bound_mac   = stored_reg;
                    out_next.channel     = cmd_reg.channel;
                    out_valid_next       = 1'b1;
                    state_next           = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        ev_reg     <= ev_next;
        stored_reg <= stored_next;
        out_reg    <= out_next;
    end

endmodule

// File: rtl/core/arp_binding_spoof_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_binding_spoof_detector: ARP IP-to-MAC binding spoof detector
// Learns sender IP to MAC bindings from ARP frames, flags spoofed bindings
// and deauthentication frames, and tracks the radio hop channel.
// ----------------------------------------------------------------------------
// Each word pushed in is either a captured frame's header fields or a channel
// hop tick, and each one produces exactly one result word, in order. The
// front end takes a word in the cycle it is pushed (while full is low),
// advances the channel on a hop tick and queues a command. The back end then
// works through the commands one at a time. A hop tick, a non-ARP frame or an
// ARP frame that meets an empty table goes from idle straight to the finish
// state. Any other ARP frame reads the binding table RAM one entry per cycle
// in the scan state, until its IP matches or all used entries are read. A
// result not popped holds the back end in its finish state until it is. That
// sequential scan over the learned entries sets the throughput. The result
// register and the two-entry command queue let new words be pushed while an
// earlier result still waits to be popped. The table is filled in order and
// never cleared, so a fill count stands in for valid bits and no clearing
// pass is needed after reset. The result's channel is the channel after that
// word, and bound_mac is nonzero only on a spoof.
// ----------------------------------------------------------------------------
module arp_binding_spoof_detector
    import arpsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int CHANNEL_COUNT = 13
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  frame_word,
    output logic      empty,
    input  logic      pop,
    output out_word_t result_word
);

    // Command path from the front end through the queue to the back end.
    logic          q_push;
    cmd_t          q_cmd;
    logic          q_pop;
    cmd_t          q_head;
    queue_status_t q_status;

    arpsd_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .frame_word (frame_word),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    arpsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .q_status (q_status)
    );

    arpsd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .result_word (result_word)
    );

    // The queue can never report full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("command queue is full and empty at once");

    // The back end only pops commands that exist.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("back end popped an empty command queue");

    // A stored MAC is reported only together with a spoof event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_word.arp_event != EV_SPOOF) |-> result_word.bound_mac == 48'd0)
        else $error("bound MAC reported without a spoof event");

    // The reported channel always lies within the hop range.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result_word.channel != 4'd0
                    && result_word.channel <= 4'(CHANNEL_COUNT)))
        else $error("result channel outside the hop range");

endmodule
